>>> rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the second derivative stencil unit
// Field widths, job codes for the stencil shapes and the tap weight table.
// ----------------------------------------------------------------------------
package sds_pkg;

	localparam int WIN            = 7;   // window taps
	localparam int SAMPLE_W       = 24;
	localparam int WGT_W          = 9;   // signed tap weight
	localparam int TERM_W         = SAMPLE_W + WGT_W;
	localparam int SUM_W          = TERM_W + 1;
	localparam int SCALE_W        = 32;
	localparam int SHIFT_W        = 6;
	localparam int HALF_W         = SCALE_W / 2;
	localparam int MUL_W          = SUM_W + HALF_W + 1;
	localparam int PROD_W         = SUM_W + SCALE_W + 1;
	localparam int DER_W          = 48;
	localparam int IDX_W          = 12;
	localparam int MAX_POINTS_DEF = 4096;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = SCALE_W;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 1'b1;

	localparam logic signed [DER_W-1:0] DER_MAX = {1'b0, {(DER_W-1){1'b1}}};
	localparam logic signed [DER_W-1:0] DER_MIN = {1'b1, {(DER_W-1){1'b0}}};

	// Stencil shapes in the order they are issued; the code also gives the
	// distance of the point behind the newest sample (five minus code).
	typedef enum logic [2:0] {
		JOB_EF1  = 3'd0,  // one-sided forward, taps 1..6
		JOB_MID0 = 3'd1,  // centered, taps 0..4
		JOB_MID1 = 3'd2,  // centered, taps 1..5
		JOB_MID2 = 3'd3,  // centered, taps 2..6
		JOB_EB5  = 3'd4,  // one-sided backward from tap 5
		JOB_EB6  = 3'd5   // one-sided backward from tap 6
	} job_t;

	localparam logic signed [WGT_W-1:0] EDGE_W [6] = '{
		9'sd45, -9'sd154, 9'sd214, -9'sd156, 9'sd61, -9'sd10
	};
	localparam logic signed [WGT_W-1:0] MID_W [5] = '{
		-9'sd1, 9'sd16, -9'sd30, 9'sd16, -9'sd1
	};

	typedef struct packed {
		logic             valid;
		logic             err;
		logic             fin;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	function automatic logic signed [WGT_W-1:0] tap_weight(job_t job, int tap);
		int k;
		logic edge_shape;
		logic signed [WGT_W-1:0] w;
		k = 0;
		edge_shape = 1'b1;
		w = '0;
		unique case (job)
			JOB_EF1:  k = tap - 1;
			JOB_MID0: begin k = tap;     edge_shape = 1'b0; end
			JOB_MID1: begin k = tap - 1; edge_shape = 1'b0; end
			JOB_MID2: begin k = tap - 2; edge_shape = 1'b0; end
			JOB_EB5:  k = 5 - tap;
			JOB_EB6:  k = 6 - tap;
			default:  k = -1;
		endcase
		if (edge_shape) begin
			if (k >= 0 && k < 6) w = EDGE_W[3'(k)];
		end else begin
			if (k >= 0 && k < 5) w = MID_W[3'(k)];
		end
		return w;
	endfunction

endpackage

>>> rtl/sds_cell.sv
// ----------------------------------------------------------------------------
// sds_cell: one tap of the sample window
// Holds one sample, passes it on when the window advances and weighs it
// for the stencil that is being issued.
// ----------------------------------------------------------------------------
module sds_cell
	import sds_pkg::*;
#(
	parameter int TAP = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic                       clr,
	input  logic                       adv,
	input  job_t                       job,
	input  logic signed [SAMPLE_W-1:0] din,
	output logic signed [SAMPLE_W-1:0] dout,
	output logic signed [TERM_W-1:0]   term
);

	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [TERM_W-1:0]   term_s1;
	logic signed [WGT_W-1:0]    w;

	assign w    = tap_weight(job, TAP);
	assign dout = sample_q;
	assign term = term_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= din;
		end else if (clr) begin
			sample_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s1 <= TERM_W'(sample_q) * TERM_W'(w);
		end
	end

endmodule

>>> rtl/sds_post.sv
// ----------------------------------------------------------------------------
// sds_post: sum, scale, shift and saturate
// Adds the weighted taps, multiplies by scale in two halves, shifts right
// arithmetically and clips to 48 bits; holds the output register.
// ----------------------------------------------------------------------------
module sds_post
	import sds_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [SCALE_W-1:0]         scale,
	input  logic [SHIFT_W-1:0]         shift,
	input  logic signed [TERM_W-1:0]   terms [WIN],
	input  ctl_t                       ctl_in,
	output logic signed [DER_W-1:0]    derivative,
	output logic                       saturated,
	output ctl_t                       ctl_out
);

	logic signed [SUM_W-1:0]  pair_s2 [4];
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [MUL_W-1:0]  hi_s4;
	logic signed [MUL_W-1:0]  lo_s4;
	logic signed [PROD_W-1:0] prod_s5;
	logic signed [DER_W-1:0]  der_s6;
	logic                     sat_s6;
	ctl_t                     ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic signed [PROD_W-1:0] shd;
	logic                     pos_ovf, neg_ovf;

	always_comb begin
		shd     = prod_s5 >>> shift;
		pos_ovf = !shd[PROD_W-1] && (|shd[PROD_W-2:DER_W-1]);
		neg_ovf = shd[PROD_W-1] && !(&shd[PROD_W-2:DER_W-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				pair_s2[k] <= SUM_W'(terms[2*k]) + SUM_W'(terms[2*k+1]);
			end
			pair_s2[3] <= SUM_W'(terms[WIN-1]);
			sum_s3 <= pair_s2[0] + pair_s2[1] + pair_s2[2] + pair_s2[3];
			hi_s4  <= MUL_W'(sum_s3) * MUL_W'($signed({1'b0, scale[SCALE_W-1:HALF_W]}));
			lo_s4  <= MUL_W'(sum_s3) * MUL_W'($signed({1'b0, scale[HALF_W-1:0]}));
			prod_s5 <= (PROD_W'(hi_s4) <<< HALF_W) + PROD_W'(lo_s4);
			// error word carries a plain zero
			if (ctl_s5.err) begin
				der_s6 <= '0;
				sat_s6 <= 1'b0;
			end else if (pos_ovf) begin
				der_s6 <= DER_MAX;
				sat_s6 <= 1'b1;
			end else if (neg_ovf) begin
				der_s6 <= DER_MIN;
				sat_s6 <= 1'b1;
			end else begin
				der_s6 <= shd[DER_W-1:0];
				sat_s6 <= 1'b0;
			end
		end
	end

	assign derivative = der_s6;
	assign saturated  = sat_s6;
	assign ctl_out    = ctl_s6;

endmodule

>>> rtl/second_derivative_stencil_unit.sv
// ----------------------------------------------------------------------------
// second_derivative_stencil_unit: streaming fourth-order second derivative
//
// Input words (s_t*) carry one signed 24-bit sample each; s_tlast marks the
// final sample of a grid. Output words (m_t*) carry one derivative point
// each, in grid order; m_tlast marks the final point of the grid, m_tuser
// flags clipping and the error word of a grid shorter than seven samples.
// Interior points use the five-point stencil, the two points at each end
// the six-point one-sided stencil. Every weighted sum is multiplied by the
// scale register, shifted right by the shift register and clipped to 48 bits.
//
// Throughput: one sample per cycle while the output is not stalled. The
// seventh sample yields two points and holds the input until both issue;
// the final sample yields up to six points and holds the input until the
// last of them issues. Shorter grids yield nothing until their final
// sample, which yields one error word. Each point passes the stages issue
// and weigh, two add stages, split multiply, combine, shift and clip.
// When an output word waits and m_tready is low the whole pipe holds;
// samples keep being taken into the window as long as no points wait to
// be issued. Reset clears the window, counters and pipe control words
// and sets scale to 1 and shift to 0. The user must make configuration
// writes only while no words are in flight; the block has no check for it.
module second_derivative_stencil_unit
	import sds_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // [23:0] sample
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata,   // [47:0] derivative, [59:48] point_index
	output logic [1:0]            m_tuser,   // [0] saturated, [1] too_short
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDXW = $clog2(MAX_POINTS);
	localparam int PW   = IDXW + IDX_W + 1;

	// configuration
	logic [SCALE_W-1:0] scale_q;
	logic [SHIFT_W-1:0] shift_q;

	// stream bookkeeping
	logic [IDXW-1:0] sc_q, sc_eff, sc_inc, base_q;
	logic [2:0]      filled_q, filled_eff, filled_inc;

	// job sequencer
	job_t job_q, end_q;
	logic busy_q, err_q, send_q;

	logic adv, issue, last_issue, clr_fin, acc, short_grid, shift_en, clr;
	logic [2:0]    lag;
	logic [PW-1:0] pidx_w;
	ctl_t          ctl_s1, ctl_o;

	logic signed [SAMPLE_W-1:0] hist  [WIN];
	logic signed [SAMPLE_W-1:0] din   [WIN];
	logic signed [TERM_W-1:0]   terms [WIN];
	logic signed [DER_W-1:0]    der;
	logic                       sat;

	// Advance the pipe unless the output word is stalled.
	assign adv        = !m_tvalid || m_tready;
	assign issue      = busy_q && adv;
	assign last_issue = issue && (job_q == end_q);
	// Final point of a good grid leaves the window: clear the stream state.
	assign clr_fin    = last_issue && send_q;
	assign s_tready   = !busy_q || last_issue;
	assign acc        = s_tvalid && s_tready;

	// A sample taken in the clearing cycle sees the cleared state.
	assign filled_eff = clr_fin ? 3'd0 : filled_q;
	assign sc_eff     = clr_fin ? '0 : sc_q;
	assign filled_inc = (filled_eff == 3'(WIN)) ? filled_eff : filled_eff + 3'd1;
	assign sc_inc     = (sc_eff == IDXW'(MAX_POINTS - 1)) ? '0 : sc_eff + IDXW'(1);
	assign short_grid = s_tlast && (filled_eff < 3'(WIN - 1));

	assign shift_en = acc && !short_grid;
	assign clr      = clr_fin || (acc && short_grid);

	// point index: base minus distance, modulo the point capacity
	always_comb begin
		lag = 3'(JOB_EB6) - 3'(job_q);
		if (base_q >= IDXW'(lag)) begin
			pidx_w = PW'(base_q) - PW'(lag);
		end else begin
			pidx_w = PW'(base_q) + PW'(MAX_POINTS) - PW'(lag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			shift_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE: scale_q <= cfg_data;
				REG_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q     <= '0;
			filled_q <= '0;
			base_q   <= '0;
			busy_q   <= 1'b0;
			err_q    <= 1'b0;
			send_q   <= 1'b0;
			job_q    <= JOB_EF1;
			end_q    <= JOB_EF1;
		end else begin
			if (clr_fin) begin
				sc_q     <= '0;
				filled_q <= '0;
			end
			if (issue) begin
				if (job_q == end_q) begin
					busy_q <= 1'b0;
				end else begin
					job_q <= job_t'(3'(job_q) + 3'd1);
				end
			end
			if (acc) begin
				base_q <= sc_eff;
				if (short_grid) begin
					// one error word, then start over
					busy_q   <= 1'b1;
					err_q    <= 1'b1;
					send_q   <= 1'b0;
					job_q    <= JOB_EB6;
					end_q    <= JOB_EB6;
					sc_q     <= '0;
					filled_q <= '0;
				end else if (s_tlast) begin
					// flush the remaining points through the far edge
					busy_q   <= 1'b1;
					err_q    <= 1'b0;
					send_q   <= 1'b1;
					job_q    <= (filled_eff == 3'(WIN - 1)) ? JOB_EF1 : JOB_MID0;
					end_q    <= JOB_EB6;
					filled_q <= filled_inc;
					sc_q     <= sc_eff;
				end else begin
					err_q    <= 1'b0;
					send_q   <= 1'b0;
					filled_q <= filled_inc;
					sc_q     <= sc_inc;
					priority if (filled_eff == 3'(WIN - 2)) begin
						busy_q <= 1'b1;
						job_q  <= JOB_EF1;
						end_q  <= JOB_EF1;
					end else if (filled_eff == 3'(WIN - 1)) begin
						busy_q <= 1'b1;
						job_q  <= JOB_EF1;
						end_q  <= JOB_MID0;
					end else if (filled_eff == 3'(WIN)) begin
						busy_q <= 1'b1;
						job_q  <= JOB_MID0;
						end_q  <= JOB_MID0;
					end else begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// control word that travels beside the weighted taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= issue;
			ctl_s1.err   <= err_q;
			ctl_s1.fin   <= err_q || (send_q && (job_q == end_q));
			ctl_s1.idx   <= err_q ? '0 : pidx_w[IDX_W-1:0];
		end
	end

	// window: newest sample enters at the top tap and moves down
	for (genvar i = 0; i < WIN; i++) begin : g_cell
		if (i == WIN - 1) begin : g_top
			assign din[i] = s_tdata[SAMPLE_W-1:0];
		end else begin : g_mid
			assign din[i] = clr ? '0 : hist[i+1];
		end
		sds_cell #(
			.TAP (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift_en),
			.clr    (clr),
			.adv    (adv),
			.job    (job_q),
			.din    (din[i]),
			.dout   (hist[i]),
			.term   (terms[i])
		);
	end

	sds_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.scale      (scale_q),
		.shift      (shift_q),
		.terms      (terms),
		.ctl_in     (ctl_s1),
		.derivative (der),
		.saturated  (sat),
		.ctl_out    (ctl_o)
	);

	assign m_tvalid = ctl_o.valid;
	assign m_tdata  = {4'b0, ctl_o.idx, der};
	assign m_tuser  = {ctl_o.err, sat};
	assign m_tlast  = ctl_o.fin;

	// the sequencer never runs past the end of its job range
	a_job_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (3'(job_q) <= 3'(end_q)))
		else $error("job code beyond end of range");

	// an error word always closes its grid and is never clipped
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("error word not final or flagged clipped");

	// after the final point issues with no new sample, the stream restarts
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_fin && !acc |=> (filled_q == 3'd0) && (sc_q == '0))
		else $error("stream state not cleared after final point");

endmodule

>>> tb/sv/second_derivative_stencil_unit_tb.sv
// ----------------------------------------------------------------------------
// second_derivative_stencil_unit_tb: self-checking bench of the stencil unit
// Streams grids of signed samples into the unit under random backpressure on
// both sides, predicts every derivative word from a behavioral model of the
// stencils, scaling, floor shift and clipping, and checks each output word
// in order. Covers short grids, clipping and extreme register settings.
// ----------------------------------------------------------------------------
module second_derivative_stencil_unit_tb
	import sds_pkg::*;
;

	// One predicted derivative point.
	typedef struct {
		logic [47:0] derivative;
		logic [11:0] point_idx;
		logic        sat;
		logic        too_short;
		logic        fin;
	} stencil_point_t;

	// One sample word waiting to be sent.
	typedef struct {
		logic [23:0] smp;
		logic        lst;
	} sample_word_t;

	localparam logic signed [95:0] DER_HI = 96'sh7FFF_FFFF_FFFF;
	localparam logic signed [95:0] DER_LO = -96'sh8000_0000_0000;
	localparam logic [23:0]        SMP_MAX = 24'h7F_FFFF;
	localparam logic [23:0]        SMP_MIN = 24'h80_0000;

	// Own copy of the tap weights: one-sided six-point and centered five-point.
	int fwd_w [6] = '{45, -154, 214, -156, 61, -10};
	int mid_w [5] = '{-1, 16, -30, 16, -1};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [63:0]           m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Model state: sample window (newest at the end), index, fill level, registers.
	logic signed [23:0] win [7];
	logic [11:0]        win_count = '0;
	int                 win_fill = 0;
	logic [31:0]        cur_scale = 32'd1;
	logic [5:0]         cur_shift = '0;

	sample_word_t   pending_samples [$];
	stencil_point_t expected_points [$];
	int             samples_queued = 0;
	int             samples_taken = 0;
	int             mismatches = 0;
	int             src_idle = 0;
	int             snk_idle = 0;
	logic           word_taken = 1'b0;

	second_derivative_stencil_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Weighted sum of the one-sided stencil, walking the window from start.
	function automatic longint edge_sum(input int start, input int dir);
		longint acc;
		acc = 0;
		for (int j = 0; j < 6; j++)
			acc += longint'(fwd_w[j]) * longint'(win[start + j * dir]);
		return acc;
	endfunction

	function automatic longint mid_sum(input int start);
		longint acc;
		acc = 0;
		for (int j = 0; j < 5; j++)
			acc += longint'(mid_w[j]) * longint'(win[start + j]);
		return acc;
	endfunction

	// Scale, floor shift and clip one sum; lag is how far the point lies
	// behind the newest sample.
	task automatic add_point(input longint sum, input int lag, input logic fin);
		logic signed [95:0] prod;
		stencil_point_t pt;
		prod = sum;
		prod = prod * $signed({64'd0, cur_scale});
		prod = prod >>> cur_shift;
		pt.sat = 1'b1;
		if (prod > DER_HI) begin
			pt.derivative = DER_HI[47:0];
		end else if (prod < DER_LO) begin
			pt.derivative = DER_LO[47:0];
		end else begin
			pt.derivative = prod[47:0];
			pt.sat = 1'b0;
		end
		pt.point_idx = win_count - 12'(lag);
		pt.too_short = 1'b0;
		pt.fin = fin;
		expected_points.insert(expected_points.size(), pt);
	endtask

	// Advance the model by one accepted sample and queue the points it completes.
	task automatic predict_points(input logic [23:0] smp, input logic lst);
		int prior;
		stencil_point_t pt;
		prior = win_fill;
		for (int i = 0; i < 6; i++)
			win[i] = win[i + 1];
		win[6] = smp;
		if (win_fill < 7)
			win_fill++;
		if (lst) begin
			if (win_fill < 7) begin
				// grid too short for any stencil: one error word
				pt.derivative = '0;
				pt.point_idx = '0;
				pt.sat = 1'b0;
				pt.too_short = 1'b1;
				pt.fin = 1'b1;
				expected_points.insert(expected_points.size(), pt);
			end else begin
				// flush: the seven-sample grid still owes its second point
				if (prior == 6)
					add_point(edge_sum(1, 1), 5, 1'b0);
				for (int d = 4; d >= 2; d--)
					add_point(mid_sum(4 - d), d, 1'b0);
				add_point(edge_sum(5, -1), 1, 1'b0);
				add_point(edge_sum(6, -1), 0, 1'b1);
			end
			for (int i = 0; i < 7; i++)
				win[i] = '0;
			win_count = '0;
			win_fill = 0;
		end else begin
			if (prior == 5 || prior == 6)
				add_point(edge_sum(1, 1), 5, 1'b0);
			if (prior >= 6)
				add_point(mid_sum(0), 4, 1'b0);
			win_count = win_count + 12'd1;
		end
	endtask

	// Driver: present the next pending sample once the current word is taken.
	always @(negedge clk) begin : drive
		sample_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_taken) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle) begin
				w = pending_samples.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= w.smp;
				s_tlast <= w.lst;
			end else begin
				// idle: scramble data so the unit must ignore it
				s_tvalid <= 1'b0;
				s_tdata <= 24'($urandom);
				s_tlast <= 1'($urandom);
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= snk_idle);
	end

	// Monitor: check output words against the oldest prediction, then
	// predict from an accepted sample word.
	always @(posedge clk) begin : watch
		stencil_point_t pt;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: point word with none expected: tdata %h tuser %b tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					pt = expected_points.pop_front();
					if (m_tdata !== {4'd0, pt.point_idx, pt.derivative}
							|| m_tuser !== {pt.too_short, pt.sat} || m_tlast !== pt.fin) begin
						$display("%0t: point mismatch: exp der %h idx %0d sat %b short %b fin %b",
							$time, pt.derivative, pt.point_idx, pt.sat, pt.too_short, pt.fin);
						$display("%0t:                 got der %h idx %0d sat %b short %b fin %b pad %h",
							$time, m_tdata[47:0], m_tdata[59:48], m_tuser[0], m_tuser[1],
							m_tlast, m_tdata[63:60]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_points(s_tdata, s_tlast);
				samples_taken++;
			end
		end
		word_taken <= s_tvalid && s_tready;
	end

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(7))
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			2:       return 24'($urandom_range(511)) - 24'd256;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic queue_word(input logic [23:0] smp, input logic lst);
		sample_word_t w;
		w.smp = smp;
		w.lst = lst;
		pending_samples.insert(pending_samples.size(), w);
		samples_queued++;
	endtask

	task automatic queue_random_stream(input int len);
		for (int i = 0; i < len; i++)
			queue_word(rand_sample(), i == len - 1);
	endtask

	// Mostly well-formed grids of random length, some too short.
	task automatic queue_random_streams(input int n_items);
		int sent;
		int r;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 15)
				r = $urandom_range(6, 1);
			else if (r < 25)
				r = 7;
			else
				r = $urandom_range(24, 8);
			queue_random_stream(r);
			sent += r;
		end
	endtask

	// Hold until every queued sample is taken and every point has arrived,
	// then let the pipe settle before any register write.
	task automatic wait_drained();
		while (samples_taken != samples_queued || expected_points.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 32'($urandom);
		if (idx == REG_SCALE)
			cur_scale = val;
		else
			cur_shift = val[5:0];
	endtask

	initial begin
		for (int i = 0; i < 7; i++)
			win[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles with a chance of 15 in 100, receiver 52
		src_idle = 15;
		snk_idle = 52;

		// reset registers: short grids, shortest and longest, then a minimal grid
		queue_word(SMP_MAX, 1'b1);
		for (int i = 0; i < 6; i++)
			queue_word((i % 2) ? SMP_MIN : SMP_MAX, i == 5);
		for (int i = 0; i < 7; i++)
			queue_word((i % 2) ? SMP_MIN : SMP_MAX, i == 6);
		wait_drained();

		// full scale, no shift: alternating extremes clip both ways
		write_reg(REG_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_SHIFT, 32'd0);
		for (int i = 0; i < 7; i++)
			queue_word((i % 2) ? SMP_MAX : SMP_MIN, i == 6);
		wait_drained();

		// widest shift, garbage in the unused register bits
		write_reg(REG_SHIFT, 32'hFFFF_FFFF);
		queue_random_streams(30);
		wait_drained();

		write_reg(REG_SCALE, 32'd0);
		write_reg(REG_SHIFT, 32'($urandom));
		queue_random_streams(35);
		wait_drained();

		// sender now idles the more
		src_idle = 52;
		snk_idle = 15;
		write_reg(REG_SCALE, 32'd12);
		write_reg(REG_SHIFT, 32'($urandom_range(8)));
		queue_random_streams(40);
		wait_drained();

		write_reg(REG_SCALE, 32'($urandom));
		write_reg(REG_SHIFT, 32'($urandom));
		queue_random_streams(40);
		wait_drained();

		// no idling on either side
		src_idle = 0;
		snk_idle = 0;
		write_reg(REG_SCALE, 32'($urandom));
		write_reg(REG_SHIFT, 32'($urandom_range(40, 16)));
		queue_random_streams(50);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
